/* rtl/gacs_pkg.sv */
// Shared constants and types for the graph adjacency and colour store.
`timescale 1ns / 1ps
package gacs_pkg;
  localparam int NV = 64;
  localparam int VW = 6;

  localparam logic [3:0] CMD_ADD = 4'd0;
  localparam logic [3:0] CMD_REMOVE = 4'd1;
  localparam logic [3:0] CMD_SET_COLOUR = 4'd2;
  localparam logic [3:0] CMD_CLEAR_COLOURS = 4'd3;
  localparam logic [3:0] CMD_MAX_DEGREE = 4'd4;
  localparam logic [3:0] CMD_NONNEIGHBOURS = 4'd5;
  localparam logic [3:0] CMD_COMMON = 4'd6;
  localparam logic [3:0] CMD_ADJACENT = 4'd7;
  localparam logic [3:0] CMD_NEIGHBOURS = 4'd8;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  typedef struct packed {
    logic [63:0] result_mask;
    logic adjacent;
    logic [6:0] count;
    logic [5:0] best_vertex;
    logic found;
    logic [1:0] status;
  } result_t;
endpackage

/* rtl/gacs_ram.sv */
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module gacs_ram #(
  parameter int W = 64,
  parameter int D = 64
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(D)-1:0] addr,
  input  logic [W-1:0] wdata,
  output logic [W-1:0] rdata
);
  logic [W-1:0] mem [D];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* rtl/graph_adjacency_colour_store.sv */
`timescale 1ns / 1ps
// Graph adjacency and colour store.
// Input: s_axis_* stream, one command per transfer. tdata packs, from bit 0:
// cmd[4], vertex_a[6], vertex_b[6], colour_value[7], range_start[6],
// range_end[7], candidate_mask[64] (100 bits, zero padded to 104).
// Output: m_axis_* stream, one result per command. tdata packs, from bit 0:
// status[2], found[1], best_vertex[6], count[7], adjacent[1],
// result_mask[64] (81 bits, padded to 88).
// cfg_we/cfg_data write vertex_count; write only while idle.
// Reset: a clearing pass sweeps all 64 rows (adjacency, degree, colour)
// before the first command is accepted.
// Commands are handled one at a time; the next transfer can be taken in the
// cycle after the result transfer. Edge commands perform two row
// read-modify-writes on the single-port row RAM (read a, read b, write a,
// write b). Scans (max degree, non-neighbours, common count) step one vertex
// per cycle through the degree/colour or row RAMs. Clear colours sweeps all
// 64 entries of the colour RAM.
// The result sits in an output register until taken; a stalled receiver
// holds the block in its done state.
module graph_adjacency_colour_store (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [6:0] cfg_data,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [103:0] s_axis_tdata, // cmd, vertex_a, vertex_b, colour_value, range_start, range_end, candidate_mask
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [87:0] m_axis_tdata // status, found, best_vertex, count, adjacent, result_mask
);
  localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_RDA = 4'd2, S_WA = 4'd3,
    S_RDB = 4'd4, S_WB = 4'd5, S_SCAN = 4'd6, S_CLR = 4'd7, S_DONE = 4'd8,
    S_RDB2 = 4'd9;

  logic [3:0] state;
  logic [6:0] vertex_count;
  logic [6:0] idx; // sweep / scan counter
  logic scan_valid; // previous cycle issued a scan read
  logic [5:0] scan_v;
  logic [3:0] cmd;
  logic [5:0] va, vb, rs;
  logic [6:0] re;
  logic [63:0] cand;
  logic [63:0] row_a, row_b;
  logic [5:0] deg_a, deg_b;
  gacs_pkg::result_t res;

  // RAM ports
  logic row_we, dc_we, col_we;
  logic [5:0] row_addr, dc_addr, col_addr;
  logic [63:0] row_wd, row_rd;
  logic [5:0] dc_wd, dc_rd;
  logic [6:0] col_wd, col_rd;

  gacs_ram #(.W(64), .D(gacs_pkg::NV)) u_row (.clk, .we(row_we), .addr(row_addr),
    .wdata(row_wd), .rdata(row_rd));
  gacs_ram #(.W(6), .D(gacs_pkg::NV)) u_deg (.clk, .we(dc_we), .addr(dc_addr),
    .wdata(dc_wd), .rdata(dc_rd));
  gacs_ram #(.W(7), .D(gacs_pkg::NV)) u_col (.clk, .we(col_we), .addr(col_addr),
    .wdata(col_wd), .rdata(col_rd));

  logic [6:0] n;
  assign n = (vertex_count > 7'd64) ? 7'd64 : vertex_count;
  logic a_ok, b_ok;
  assign a_ok = {1'b0, va} < n;
  assign b_ok = {1'b0, vb} < n;
  logic [6:0] hi;
  assign hi = (re > n) ? n : re;
  logic in_range; // scanned vertex within clipped range
  assign in_range = ({1'b0, scan_v} >= {1'b0, rs}) && ({1'b0, scan_v} < hi);
  logic [63:0] n_mask;
  assign n_mask = (n[6]) ? '1 : ((64'd1 << n[5:0]) - 64'd1);

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_DONE);
  assign m_axis_tdata = {7'd0, res};

  logic edge_cmd;
  assign edge_cmd = (cmd == gacs_pkg::CMD_ADD) || (cmd == gacs_pkg::CMD_REMOVE);

  always_comb begin
    row_we = 1'b0; dc_we = 1'b0; col_we = 1'b0;
    row_addr = va; dc_addr = va; col_addr = idx[5:0];
    row_wd = row_a; dc_wd = deg_a; col_wd = 7'd0;
    unique case (state)
      S_INIT: begin
        row_we = 1'b1; dc_we = 1'b1; col_we = 1'b1;
        row_addr = idx[5:0]; dc_addr = idx[5:0];
        row_wd = '0; dc_wd = '0;
      end
      S_CLR: col_we = 1'b1;
      S_WA: begin
        row_we = 1'b1; dc_we = 1'b1;
        row_wd = (cmd == gacs_pkg::CMD_ADD) ? (row_a | (64'd1 << vb))
                                            : (row_a & ~(64'd1 << vb));
        dc_wd = (cmd == gacs_pkg::CMD_ADD) ? deg_a + 6'd1 : deg_a - 6'd1;
      end
      S_RDB, S_RDB2: begin
        row_addr = vb; dc_addr = vb;
      end
      S_WB: begin
        row_we = 1'b1; dc_we = 1'b1; row_addr = vb; dc_addr = vb;
        row_wd = (cmd == gacs_pkg::CMD_ADD) ? (row_b | (64'd1 << va))
                                            : (row_b & ~(64'd1 << va));
        dc_wd = (cmd == gacs_pkg::CMD_ADD) ? deg_b + 6'd1 : deg_b - 6'd1;
      end
      S_IDLE: begin
        col_addr = s_axis_tdata[9:4];
        col_wd = s_axis_tdata[22:16];
        col_we = s_axis_tvalid && (s_axis_tdata[3:0] == gacs_pkg::CMD_SET_COLOUR)
          && ({1'b0, s_axis_tdata[9:4]} < n);
      end
      S_SCAN: begin
        row_addr = idx[5:0]; dc_addr = idx[5:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      idx <= '0;
      vertex_count <= 7'd64;
      scan_valid <= 1'b0;
    end else begin
      if (cfg_we) vertex_count <= cfg_data;
      unique case (state)
        S_INIT: begin
          idx <= idx + 7'd1;
          if (idx == 7'd63) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd <= s_axis_tdata[3:0];
            va <= s_axis_tdata[9:4];
            vb <= s_axis_tdata[15:10];
            rs <= s_axis_tdata[28:23];
            re <= s_axis_tdata[35:29];
            cand <= s_axis_tdata[99:36];
            res <= '0;
            idx <= '0;
            state <= S_RDA;
          end
        end
        S_RDA: begin
          // issue read of row/degree at vertex_a; decode command
          unique case (cmd)
            gacs_pkg::CMD_ADD, gacs_pkg::CMD_REMOVE: begin
              if (!a_ok || !b_ok || va == vb) begin
                res.status <= gacs_pkg::ST_BAD; state <= S_DONE;
              end else state <= S_RDB;
            end
            gacs_pkg::CMD_SET_COLOUR: begin
              if (!a_ok) res.status <= gacs_pkg::ST_BAD;
              state <= S_DONE;
            end
            gacs_pkg::CMD_CLEAR_COLOURS: state <= S_CLR;
            gacs_pkg::CMD_MAX_DEGREE: state <= S_SCAN;
            gacs_pkg::CMD_NONNEIGHBOURS, gacs_pkg::CMD_NEIGHBOURS: begin
              if (!a_ok) begin
                res.status <= gacs_pkg::ST_BAD; state <= S_DONE;
              end else state <= S_RDB;
            end
            gacs_pkg::CMD_COMMON, gacs_pkg::CMD_ADJACENT: begin
              if (!a_ok || !b_ok) begin
                res.status <= gacs_pkg::ST_BAD; state <= S_DONE;
              end else state <= S_RDB;
            end
            default: begin
              res.status <= gacs_pkg::ST_BAD; state <= S_DONE;
            end
          endcase
        end
        S_RDB: begin
          // row_rd holds row a; read of row b issued this cycle
          row_a <= row_rd;
          deg_a <= dc_rd;
          state <= S_RDB2;
        end
        S_RDB2: begin
          row_b <= row_rd;
          deg_b <= dc_rd;
          if (edge_cmd) begin
            if (cmd == gacs_pkg::CMD_ADD && row_a[vb]) state <= S_DONE;
            else if (cmd == gacs_pkg::CMD_REMOVE && !(row_a[vb] && row_rd[va])) begin
              res.status <= gacs_pkg::ST_ABSENT; state <= S_DONE;
            end else state <= S_WA;
          end else if (cmd == gacs_pkg::CMD_ADJACENT) begin
            res.adjacent <= row_a[vb] && row_rd[va];
            state <= S_DONE;
          end else if (cmd == gacs_pkg::CMD_NEIGHBOURS) begin
            res.result_mask <= row_a & n_mask;
            state <= S_DONE;
          end else begin
            state <= S_SCAN;
          end
        end
        // edge write sequencing: WA writes row a, then WB writes row b
        S_WA: state <= S_WB;
        S_WB: state <= S_DONE;
        S_SCAN: begin
          // idx issues reads; scan_v/scan_valid evaluate the returned data
          if (idx != 7'd64) idx <= idx + 7'd1;
          scan_valid <= (idx != 7'd64);
          scan_v <= idx[5:0];
          if (scan_valid && in_range && col_rd == 7'd0) begin
            unique case (cmd)
              gacs_pkg::CMD_MAX_DEGREE: begin
                if (cand[scan_v] && (!res.found || dc_rd > deg_a)) begin
                  res.found <= 1'b1; res.best_vertex <= scan_v; deg_a <= dc_rd;
                end
              end
              gacs_pkg::CMD_NONNEIGHBOURS: begin
                if (!row_a[scan_v] && scan_v != va) res.result_mask[scan_v] <= 1'b1;
              end
              default: ;
            endcase
          end
          if (scan_valid && in_range && cmd == gacs_pkg::CMD_COMMON
              && row_a[scan_v] && row_b[scan_v]) begin
            res.count <= res.count + 7'd1;
          end
          if (!scan_valid && idx == 7'd64) begin
            idx <= '0;
            state <= S_DONE;
          end
        end
        S_CLR: begin
          idx <= idx + 7'd1;
          if (idx == 7'd63) state <= S_DONE;
        end
        S_DONE: begin
          idx <= '0;
          if (m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
